@@ hw/rtl/crbs_pkg.sv @@
`default_nettype none

package crbs_pkg;

  // coordinate format: signed, 4 fraction bits
  localparam int COORD_WIDTH = 16;

  // divide by 6 through a scaled reciprocal; the shift leaves the product
  // error below one sixth for every dividend up to 2^COORD_WIDTH + 2
  localparam int DIV6_SHIFT = COORD_WIDTH + 3;
  localparam logic [COORD_WIDTH:0] DIV6_RECIP =
    (COORD_WIDTH + 1)'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_HANDLE1 = 2'd1,
    KIND_HANDLE2 = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  // everything the emitter needs for one input word
  typedef struct packed {
    point_t q0;       // p0 of the leading segment
    point_t w1;
    point_t w2;
    point_t pn;       // newest point
    logic   has_b;    // closing segment present
    logic   short_c;  // curve ended too early
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/crbs_window.sv @@
`default_nettype none

module crbs_window (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              accept,
  input  crbs_pkg::point_t pt,
  input  wire              fin,
  output crbs_pkg::job_t   job,
  output logic             has_results
);
  import crbs_pkg::*;

  point_t     win0_r, win1_r, win2_r;
  logic [1:0] seen_r;
  logic       two_or_more;

  assign two_or_more = (seen_r >= 2'd2);

  always_comb begin
    job.q0      = (seen_r == 2'd3) ? win0_r : win1_r;
    job.w1      = win1_r;
    job.w2      = win2_r;
    job.pn      = pt;
    job.has_b   = fin & two_or_more;
    job.short_c = fin & ~two_or_more;
    has_results = two_or_more | fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
      seen_r <= '0;
    end else if (accept) begin
      if (fin) begin
        win0_r <= '0;
        win1_r <= '0;
        win2_r <= '0;
        seen_r <= '0;
      end else begin
        win0_r <= win1_r;
        win1_r <= win2_r;
        win2_r <= pt;
        if (seen_r != 2'd3) begin
          seen_r <= seen_r + 2'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crbs_coord.sv @@
`default_nettype none

module crbs_coord (
  input  crbs_pkg::coord_t p0,
  input  crbs_pkg::coord_t p1,
  input  crbs_pkg::coord_t p2,
  input  crbs_pkg::coord_t p3,
  input  crbs_pkg::kind_t  part,
  output crbs_pkg::coord_t c
);
  import crbs_pkg::*;

  localparam int DW = COORD_WIDTH + 1;  // exact difference
  localparam int QW = COORD_WIDTH - 1;  // quotient magnitude
  localparam int SW = COORD_WIDTH + 2;  // sum before saturation

  coord_t          anchor;
  logic [DW-1:0]   d;
  logic [DW-1:0]   mag;
  logic [DW-1:0]   dividend;
  logic [2*DW-1:0] prod;
  logic [QW-1:0]   q;
  logic            neg;
  logic [SW-1:0]   delta;
  logic [SW-1:0]   sum;
  logic            ovf;
  coord_t          handle;

  always_comb begin
    if (part == KIND_START || part == KIND_HANDLE1) begin
      anchor = p1;
    end else begin
      anchor = p2;
    end

    if (part == KIND_HANDLE1) begin
      d = {p2[COORD_WIDTH-1], p2} - {p0[COORD_WIDTH-1], p0};
    end else begin
      d = {p3[COORD_WIDTH-1], p3} - {p1[COORD_WIDTH-1], p1};
    end

    // round half away from zero on the magnitude
    mag      = d[DW-1] ? (~d + DW'(1)) : d;
    dividend = mag + DW'(3);
    prod     = (2*DW)'(dividend) * (2*DW)'(DIV6_RECIP);
    q        = prod[DIV6_SHIFT +: QW];

    // second handle subtracts the quotient
    neg   = d[DW-1] ^ (part == KIND_HANDLE2);
    delta = neg ? (~{3'b000, q} + SW'(1)) : {3'b000, q};
    sum   = {{2{anchor[COORD_WIDTH-1]}}, anchor} + delta;

    ovf = (sum[SW-1:COORD_WIDTH-1] != {(SW-COORD_WIDTH+1){1'b0}}) &&
          (sum[SW-1:COORD_WIDTH-1] != {(SW-COORD_WIDTH+1){1'b1}});
    if (ovf) begin
      handle = sum[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                         : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      handle = sum[COORD_WIDTH-1:0];
    end

    if (part == KIND_HANDLE1 || part == KIND_HANDLE2) begin
      c = handle;
    end else begin
      c = anchor;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crbs_emitter.sv @@
`default_nettype none

module crbs_emitter (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              load,
  input  crbs_pkg::job_t   job_in,
  output logic             free,
  output logic             out_valid,
  input  wire              out_ready,
  output crbs_pkg::coord_t out_cx,
  output crbs_pkg::coord_t out_cy,
  output crbs_pkg::coord_t out_cz,
  output logic [1:0]       out_kind,
  output logic             out_curve_done,
  output logic             out_too_short,
  output logic             out_run_end
);
  import crbs_pkg::*;

  job_t       job_r;
  logic       job_valid_r;
  logic [2:0] idx_r;

  logic       out_valid_r;
  coord_t     cx_r, cy_r, cz_r;
  kind_t      kind_r;
  logic       done_r, short_r, end_r;

  logic       adv, emit, last, seg_b;
  kind_t      part;
  point_t     sp0, sp1, sp2, sp3;
  coord_t     hx, hy, hz;

  assign adv   = ~out_valid_r | out_ready;
  assign emit  = job_valid_r & adv;
  assign seg_b = idx_r[2];
  assign part  = kind_t'(idx_r[1:0]);

  always_comb begin
    if (job_r.short_c) begin
      last = (idx_r == 3'd0);
    end else if (job_r.has_b) begin
      last = (idx_r == 3'd7);
    end else begin
      last = (idx_r == 3'd3);
    end
    free = ~job_valid_r | (emit & last);

    // second segment slides the window by one point
    sp0 = seg_b ? job_r.w1 : job_r.q0;
    sp1 = seg_b ? job_r.w2 : job_r.w1;
    sp2 = seg_b ? job_r.pn : job_r.w2;
    sp3 = job_r.pn;
  end

  crbs_coord u_coord_x (
    .p0(sp0.x), .p1(sp1.x), .p2(sp2.x), .p3(sp3.x), .part(part), .c(hx)
  );
  crbs_coord u_coord_y (
    .p0(sp0.y), .p1(sp1.y), .p2(sp2.y), .p3(sp3.y), .part(part), .c(hy)
  );
  crbs_coord u_coord_z (
    .p0(sp0.z), .p1(sp1.z), .p2(sp2.z), .p3(sp3.z), .part(part), .c(hz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (adv) begin
        out_valid_r <= 1'b0;
      end
      // a new job only lands when the old one is idle or on its last word
      if (load) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
        if (last) begin
          job_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_in;
    end
    if (emit) begin
      if (job_r.short_c) begin
        cx_r    <= '0;
        cy_r    <= '0;
        cz_r    <= '0;
        kind_r  <= KIND_START;
        done_r  <= 1'b1;
        short_r <= 1'b1;
      end else begin
        cx_r    <= hx;
        cy_r    <= hy;
        cz_r    <= hz;
        kind_r  <= part;
        done_r  <= seg_b & (part == KIND_END);
        short_r <= 1'b0;
      end
      end_r <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cx         = cx_r;
  assign out_cy         = cy_r;
  assign out_cz         = cz_r;
  assign out_kind       = kind_r;
  assign out_curve_done = done_r;
  assign out_too_short  = short_r;
  assign out_run_end    = end_r;

endmodule

`default_nettype wire

@@ hw/rtl/catmull_rom_bezier_stream.sv @@
// catmull-rom to cubic bezier converter, one point word in, control
// point words out
// input channel: in_px/in_py/in_pz (signed q11.4) plus in_final_point,
// taken on in_valid & in_ready
// output channel: one control point per word (out_cx/cy/cz), out_kind
// gives start anchor, first handle, second handle, end anchor in order
// the first two points of a curve only fill the window and give no word;
// each later point gives four words, a final point gives eight (its
// segment closes the curve), a final point as first or second point gives
// a single too-short word; out_run_end marks the last word of each input
// the taken point is first held in the emitter's job register, and its
// first word then moves into the output register once that is free
// throughput: one output word per cycle through the single output
// register while points keep coming and out_ready stays high; in_ready
// rises again in the cycle that the last word of the current point moves
// into the output register
// reset (rst_n low, synchronous) empties the window and drops any
// pending words; a stalled out_ready holds the output word, and in_ready
// stays low while words of a taken point are still waiting to go out
`default_nettype none

module catmull_rom_bezier_stream (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  crbs_pkg::coord_t in_px,
  input  crbs_pkg::coord_t in_py,
  input  crbs_pkg::coord_t in_pz,
  input  wire              in_final_point,
  output logic             out_valid,
  input  wire              out_ready,
  output crbs_pkg::coord_t out_cx,
  output crbs_pkg::coord_t out_cy,
  output crbs_pkg::coord_t out_cz,
  output logic [1:0]       out_kind,
  output logic             out_curve_done,
  output logic             out_too_short,
  output logic             out_run_end
);
  import crbs_pkg::*;

  point_t pt;
  job_t   job;
  logic   has_results;
  logic   accept;
  logic   free;

  assign pt.x   = in_px;
  assign pt.y   = in_py;
  assign pt.z   = in_pz;

  // a point is taken only when the emitter can start on it at once
  assign in_ready = free;
  assign accept   = in_valid & free;

  // three-point window and point count
  crbs_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pt         (pt),
    .fin        (in_final_point),
    .job        (job),
    .has_results(has_results)
  );

  // walks the segment words and holds the output register
  crbs_emitter u_emitter (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept & has_results),
    .job_in        (job),
    .free          (free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cx        (out_cx),
    .out_cy        (out_cy),
    .out_cz        (out_cz),
    .out_kind      (out_kind),
    .out_curve_done(out_curve_done),
    .out_too_short (out_too_short),
    .out_run_end   (out_run_end)
  );

endmodule

`default_nettype wire

@@ hw/rtl/crbs_checker.sv @@
`default_nettype none

module crbs_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_kind,
  input wire       out_curve_done,
  input wire       out_too_short,
  input wire       out_run_end
);
  import crbs_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_run_end))
    else $error("output word changed while stalled");

  // end of curve always ends the run of its input
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_curve_done || out_too_short) |-> out_run_end)
    else $error("curve end without run end");

  // words of a segment follow with no gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind != KIND_END && !out_too_short
      |=> out_valid)
    else $error("gap inside a segment");

  // start anchor is followed by first handle
  a_kind_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_START && !out_too_short
      |=> out_kind == KIND_HANDLE1)
    else $error("control point order broken");

endmodule

bind catmull_rom_bezier_stream crbs_checker u_crbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_curve_done(out_curve_done),
  .out_too_short (out_too_short),
  .out_run_end   (out_run_end)
);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import crbs_pkg::*;

  // run shape
  localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_WAIT  = 20;    // quiet cycles at the end to catch stray words
  localparam int DRAIN_WAIT   = 4;     // quiet cycles after the last owed word
  localparam int POINT_TARGET = 320;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam coord_t C_MAX = coord_t'(COORD_MAX);
  localparam coord_t C_MIN = coord_t'(COORD_MIN);

  // one control point word as seen on the result channel
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    kind_t  kind;
    logic   done;
    logic   short_c;
    logic   run_end;
  } ctrl_word_t;

  // keeps its own point window and the queue of control words still owed
  class bezier_scoreboard;
    point_t     win[3];
    int         seen;
    ctrl_word_t owed[$];
    int         errors = 0;
    int         words_checked = 0;
    int         points_noted = 0;
    int         curves_closed = 0;
    int         short_curves = 0;

    function new();
      foreach (win[i]) win[i] = '0;
      seen = 0;
    endfunction

    static function longint axis(point_t p, int j);
      case (j)
        0:       return p.x;
        1:       return p.y;
        default: return p.z;
      endcase
    endfunction

    // round to nearest, ties away from zero
    static function longint div6(longint d);
      if (d >= 0) return (d + 3) / 6;
      return -((-d + 3) / 6);
    endfunction

    static function coord_t clamp(longint v);
      if (v > COORD_MAX) return C_MAX;
      if (v < COORD_MIN) return C_MIN;
      return coord_t'(v);
    endfunction

    static function string show(ctrl_word_t w);
      return $sformatf("x=%0d y=%0d z=%0d kind=%0d done=%0b short=%0b end=%0b",
                       w.x, w.y, w.z, w.kind, w.done, w.short_c, w.run_end);
    endfunction

    function void push_word(point_t c, kind_t k, logic done, logic short_c,
                            logic run_end);
      ctrl_word_t w;
      w.x = c.x;
      w.y = c.y;
      w.z = c.z;
      w.kind = k;
      w.done = done;
      w.short_c = short_c;
      w.run_end = run_end;
      owed.insert(owed.size(), w);
    endfunction

    function void push_segment(point_t p0, point_t p1, point_t p2, point_t p3,
                               logic closing, logic run_end);
      coord_t h1[3];
      coord_t h2[3];
      point_t b1;
      point_t b2;
      for (int j = 0; j < 3; j++) begin
        h1[j] = clamp(axis(p1, j) + div6(axis(p2, j) - axis(p0, j)));
        h2[j] = clamp(axis(p2, j) - div6(axis(p3, j) - axis(p1, j)));
      end
      b1.x = h1[0]; b1.y = h1[1]; b1.z = h1[2];
      b2.x = h2[0]; b2.y = h2[1]; b2.z = h2[2];
      push_word(p1, KIND_START, 1'b0, 1'b0, 1'b0);
      push_word(b1, KIND_HANDLE1, 1'b0, 1'b0, 1'b0);
      push_word(b2, KIND_HANDLE2, 1'b0, 1'b0, 1'b0);
      push_word(p2, KIND_END, closing, 1'b0, run_end);
    endfunction

    function void note_point(point_t p, logic fin);
      points_noted++;
      // segment between the two held points, p0 doubles p1 at curve start
      if (seen >= 2)
        push_segment((seen >= 3) ? win[0] : win[1], win[1], win[2], p, 1'b0, !fin);
      if (fin) begin
        if (seen >= 2) begin
          push_segment(win[1], win[2], p, p, 1'b1, 1'b1);
        end else begin
          push_word('0, KIND_START, 1'b1, 1'b1, 1'b1);
          short_curves++;
        end
        curves_closed++;
        foreach (win[i]) win[i] = '0;
        seen = 0;
      end else begin
        win[0] = win[1];
        win[1] = win[2];
        win[2] = p;
        if (seen < 3) seen++;
      end
    endfunction

    function void check_word(ctrl_word_t got);
      ctrl_word_t want;
      words_checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word at %0t: %s", $time, show(got));
        return;
      end
      want = owed.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.kind !== want.kind || got.done !== want.done ||
          got.short_c !== want.short_c || got.run_end !== want.run_end) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  // clock, reset and block ports
  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_px = '0;
  coord_t in_py = '0;
  coord_t in_pz = '0;
  logic   in_final_point = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_cx;
  coord_t out_cy;
  coord_t out_cz;
  logic [1:0] out_kind;
  logic   out_curve_done;
  logic   out_too_short;
  logic   out_run_end;

  bezier_scoreboard sb;
  bit steady = 1'b0;      // when set neither side idles, back-to-back traffic
  int idle_cycles = 0;
  int points_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  catmull_rom_bezier_stream u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_px          (in_px),
    .in_py          (in_py),
    .in_pz          (in_pz),
    .in_final_point (in_final_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cx         (out_cx),
    .out_cy         (out_cy),
    .out_cz         (out_cz),
    .out_kind       (out_kind),
    .out_curve_done (out_curve_done),
    .out_too_short  (out_too_short),
    .out_run_end    (out_run_end)
  );

  // monitor: values read at the edge are the ones the block saw
  always @(posedge clk) begin
    ctrl_word_t got;
    if (rst_n) begin
      // note the point first so its words are owed before any can arrive
      if (in_valid && in_ready)
        sb.note_point(point_t'({in_px, in_py, in_pz}), in_final_point);
      if (out_valid && out_ready) begin
        got.x = out_cx;
        got.y = out_cy;
        got.z = out_cz;
        got.kind = kind_t'(out_kind);
        got.done = out_curve_done;
        got.short_c = out_too_short;
        got.run_end = out_run_end;
        sb.check_word(got);
      end
    end
  end

  // watchdog on cycles where no word moves either way
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("catmull_rom_bezier_stream regression: fail");
      $finish;
    end
  end

  // result side: a fresh random stall before taking each word, none when steady
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // full-range values half the time, with the rails, zero and small values mixed in
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return coord_t'(int'($urandom_range(0, 64)) - 32);
      3:       return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // one point word; valid stays up across back-to-back points
  task automatic send_point(coord_t x, coord_t y, coord_t z, logic fin);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_px <= x;
    in_py <= y;
    in_pz <= z;
    in_final_point <= fin;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  task automatic send_curve(int len, bit planar);
    for (int i = 0; i < len; i++)
      send_point(pick_coord(), pick_coord(), planar ? coord_t'(0) : pick_coord(),
                 i == len - 1);
  endtask

  // hold off the sender until every owed word has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    int pick;
    int len;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // curve that ends on its first point: lone too-short word
    send_point(16, -16, 0, 1'b1);
    // curve that ends on its second point: also too short
    send_point(32, 48, 0, 1'b0);
    send_point(-32, 64, 0, 1'b1);
    // shortest real curve, planar: one leading and one closing segment
    send_point(0, 0, 0, 1'b0);
    send_point(16, 16, 0, 1'b0);
    send_point(32, 0, 0, 1'b1);
    // rail-to-rail swings drive both handles into saturation, both ways
    send_point(C_MIN, C_MAX, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, C_MAX, 1'b1);
    // differences of +-3 and +-9 hit the rounding ties
    send_point(0, 0, 0, 1'b0);
    send_point(3, -3, 9, 1'b0);
    send_point(-3, 3, -9, 1'b0);
    send_point(0, 0, 0, 1'b1);
    // longer 3d curve, window fully sliding
    send_point(-1, 1, C_MAX, 1'b0);
    send_point(100, -200, 300, 1'b0);
    send_point(-4000, 4000, -16, 1'b0);
    send_point(C_MAX, 0, C_MIN, 1'b0);
    send_point(7, -7, 5, 1'b0);
    send_point(-1, -1, -1, 1'b1);
    drain();

    // random curves, mostly well formed, some too short, a few long
    while (points_sent < POINT_TARGET) begin
      if ($urandom_range(0, 4) == 0) steady = ~steady;
      pick = $urandom_range(0, 19);
      if (pick < 3)
        len = $urandom_range(1, 2);
      else if (pick == 3)
        len = $urandom_range(12, 24);
      else
        len = $urandom_range(3, 8);
      send_curve(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("%0d points over %0d curves (%0d too short), %0d control words checked",
             sb.points_noted, sb.curves_closed, sb.short_curves, sb.words_checked);
    $display("%0d words mismatched or arrived unexpected", sb.errors);
    if (sb.errors == 0)
      $display("catmull_rom_bezier_stream regression: pass");
    else
      $display("catmull_rom_bezier_stream regression: fail");
    $finish;
  end

endmodule
